[rtl/spk128_pkg.sv]
// Shared types, constants and round function for the Speck128 encrypt block.
package spk128_pkg;

  localparam int WORD_W    = 64;
  localparam int KEY_IDX_W = 6;
  localparam int ROUNDS_DEF = 32;
  localparam int ROT_X     = 8;
  localparam int ROT_Y     = 3;

  localparam logic OP_KEY_LOAD = 1'b0;
  localparam logic OP_ENCRYPT  = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [KEY_IDX_W-1:0] key_index;
    logic [WORD_W-1:0]    key_word;
    logic [WORD_W-1:0]    plain_low;
    logic [WORD_W-1:0]    plain_high;
  } spk_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] cipher_low;
    logic [WORD_W-1:0] cipher_high;
  } spk_out_t;

  // key memory write port
  typedef struct packed {
    logic                 en;
    logic [KEY_IDX_W-1:0] addr;
    logic [WORD_W-1:0]    data;
  } spk_kwr_t;

  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
  } spk_words_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } spk_state_t;

  // one Speck round: x = (ror(x,8) + y) ^ k; y = rol(y,3) ^ x
  function automatic spk_words_t spk_round(input spk_words_t w,
                                           input logic [WORD_W-1:0] k);
    spk_words_t r;
    r.x = ({w.x[ROT_X-1:0], w.x[WORD_W-1:ROT_X]} + w.y) ^ k;
    r.y = {w.y[WORD_W-1-ROT_Y:0], w.y[WORD_W-1:WORD_W-ROT_Y]} ^ r.x;
    return r;
  endfunction

endpackage

[rtl/speck128_block_encrypt_top.sv]
// Speck128 block encryptor, iterative one round per cycle, key schedule held in memory.
// Usage: round keys are loaded one transaction each (op = key load, key_index,
// key_word); a load with key_index at or above ROUNDS is dropped. A key load
// returns nothing. An encrypt transaction (op = encrypt, plain_low = y,
// plain_high = x) returns one result transaction with the ciphertext words. An
// encryption runs as follows: the accept cycle issues the read of key 0, then one
// round per cycle, each round taking its key from the registered key memory read
// that was issued in the cycle before, then the done state moves the words into
// the output register once it is free. That key memory read port sets the pace.
// in_stall is high during the rounds and in the done state, also while a finished
// result waits for a full output register; in idle, transactions are taken while
// a prior result still sits in the output register. All round keys below ROUNDS
// must be loaded before the first encryption; reading an unloaded key gives an
// undefined result.
module speck128_block_encrypt_top #(
  parameter int ROUNDS = spk128_pkg::ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  spk128_pkg::spk_in_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output spk128_pkg::spk_out_t  out_data
);
  import spk128_pkg::*;

  localparam int AW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [KEY_IDX_W-1:0] NUM_RND  = KEY_IDX_W'(ROUNDS);
  localparam logic [KEY_IDX_W-1:0] LAST_RND = KEY_IDX_W'(ROUNDS - 1);

  spk_state_t state_r, state_nxt;
  logic [KEY_IDX_W-1:0] round_r, round_nxt;
  spk_words_t words_r, words_nxt;
  logic out_valid_r, out_valid_nxt;
  spk_out_t out_data_r, out_data_nxt;

  logic in_acc;
  logic out_free;
  spk_kwr_t kwr;
  logic [KEY_IDX_W-1:0] rd_addr;
  logic [WORD_W-1:0] cur_key;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Key loads only land in idle, so a write never meets an in-flight read.
  assign kwr.en   = in_acc && (in_data.op == OP_KEY_LOAD) && (in_data.key_index < NUM_RND);
  assign kwr.addr = in_data.key_index;
  assign kwr.data = in_data.key_word;

  spk128_key_mem #(
    .DEPTH (ROUNDS),
    .AW    (AW)
  ) u_key_mem (
    .clk     (clk),
    .wr      (kwr),
    .rd_addr (rd_addr),
    .rd_data (cur_key)
  );

  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    words_nxt     = words_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_stall      = 1'b1;
    rd_addr       = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        // key 0 read goes out in the accept cycle
        rd_addr  = '0;
        // stall is low here, so valid alone marks the accept
        if (in_valid && (in_data.op == OP_ENCRYPT)) begin
          words_nxt.x = in_data.plain_high;
          words_nxt.y = in_data.plain_low;
          round_nxt   = '0;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        // prefetch the next round's key; park the address on the last round
        rd_addr   = (round_r == LAST_RND) ? '0 : round_r + KEY_IDX_W'(1);
        words_nxt = spk_round(words_r, cur_key);
        round_nxt = round_r + KEY_IDX_W'(1);
        if (round_r == LAST_RND) begin
          round_nxt = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.cipher_low  = words_r.y;
          out_data_nxt.cipher_high = words_r.x;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    words_r    <= words_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An encrypt transaction starts the rounds at round zero.
  a_enc_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.op == OP_ENCRYPT) |=> (state_r == ST_RUN && round_r == '0))
    else $error("encrypt accept did not start rounds");

  // Round counter stays inside the key schedule.
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (round_r < NUM_RND))
    else $error("round counter out of range");

  // A result only appears after the rounds finished.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result without completed rounds");

  // No key write while rounds are reading the memory.
  a_no_wr_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !kwr.en)
    else $error("key write during encryption");

endmodule

[rtl/spk128_key_mem.sv]
// Round-key memory: one write port, one registered read port.
module spk128_key_mem #(
  parameter int DEPTH = spk128_pkg::ROUNDS_DEF,
  parameter int AW    = 5
) (
  input  logic                                clk,
  input  spk128_pkg::spk_kwr_t                wr,
  input  logic [spk128_pkg::KEY_IDX_W-1:0]    rd_addr,
  output logic [spk128_pkg::WORD_W-1:0]       rd_data
);
  import spk128_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr[AW-1:0]];
  end

  assign rd_data = rd_data_r;

endmodule

[tb/tb.sv]
// Self-checking testbench for the Speck128 block encrypt top level.
`timescale 1ns / 100ps

module tb;
  import spk128_pkg::*;

  localparam int NUM_ROUNDS     = ROUNDS_DEF;
  localparam int RANDOM_ITEMS   = 1100;   // loads and encrypts that the block acts on
  localparam int QUIET_PHASE    = 300;    // leading random stretch with no idling
  localparam int HOLD_AT        = 600;
  localparam int PAUSE_AT       = 900;
  localparam int HOLD_CYCLES    = 400;    // long receiver hold-off
  localparam int IDLE_PCT       = 32;
  localparam int WATCHDOG_LIMIT = 5000;

  // Keeps a copy of the round-key memory, predicts the ciphertext for each
  // accepted encrypt and checks results in order.
  class speck_scoreboard;
    logic [WORD_W-1:0] key_sched [NUM_ROUNDS];
    spk_out_t          cipher_q [$];
    int n_key_loads, n_dropped, n_encrypts, n_checked, n_errors;

    function spk_out_t encrypt_block(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
      logic [WORD_W-1:0] x, y;
      spk_out_t          r;
      x = hi;
      y = lo;
      for (int i = 0; i < NUM_ROUNDS; i++) begin
        x = ((x >> 8) | (x << (WORD_W - 8))) + y;
        x = x ^ key_sched[i];
        y = ((y << 3) | (y >> (WORD_W - 3))) ^ x;
      end
      r.cipher_low  = y;
      r.cipher_high = x;
      return r;
    endfunction

    function void note_input(spk_in_t t);
      if (t.op == OP_ENCRYPT) begin
        cipher_q.push_back(encrypt_block(t.plain_low, t.plain_high));
        n_encrypts++;
      end else if (t.key_index < NUM_ROUNDS) begin
        key_sched[t.key_index] = t.key_word;
        n_key_loads++;
      end else begin
        n_dropped++;
      end
    endfunction

    function void check_result(spk_out_t r);
      spk_out_t e;
      if (cipher_q.size() == 0) begin
        $error("unexpected result transaction: low %h high %h", r.cipher_low, r.cipher_high);
        n_errors++;
        return;
      end
      e = cipher_q.pop_front();
      n_checked++;
      if (r.cipher_low !== e.cipher_low) begin
        $error("cipher_low mismatch: expected %h, got %h", e.cipher_low, r.cipher_low);
        n_errors++;
      end
      if (r.cipher_high !== e.cipher_high) begin
        $error("cipher_high mismatch: expected %h, got %h", e.cipher_high, r.cipher_high);
        n_errors++;
      end
    endfunction

    function int pending();
      return cipher_q.size();
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  spk_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  spk_out_t out_data;

  speck_scoreboard sb;

  // idling enables per side, and the receiver hold-off request
  bit tx_idle;
  bit rx_idle;
  bit hold_req;
  int quiet_cycles;

  speck128_block_encrypt_top #(.ROUNDS(NUM_ROUNDS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Monitor: every transaction is seen at the rising edge, before the block
  // updates. The result is checked first; a key load accepted on the same
  // edge cannot affect a ciphertext that was already predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_input(in_data);
    end
  end

  // Watchdog: a run that stops moving transactions fails.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off when asked. The hold-off is
  // counted here so the sender keeps offering transactions meanwhile.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= rx_idle && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Mostly random 64-bit values, with the two extremes mixed in.
  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Unused fields carry junk so every input bit toggles.
  function automatic spk_in_t key_item(int idx, logic [WORD_W-1:0] w);
    spk_in_t t;
    t.op         = OP_KEY_LOAD;
    t.key_index  = idx[KEY_IDX_W-1:0];
    t.key_word   = w;
    t.plain_low  = rand_word();
    t.plain_high = rand_word();
    return t;
  endfunction

  function automatic spk_in_t enc_item(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
    spk_in_t t;
    t.op         = OP_ENCRYPT;
    t.key_index  = KEY_IDX_W'($urandom_range(63));
    t.key_word   = rand_word();
    t.plain_low  = lo;
    t.plain_high = hi;
    return t;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  // valid stays high into the next call unless that call idles first.
  task automatic send_item(input spk_in_t t);
    while (tx_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender pause: nothing offered until every ciphertext is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  initial begin
    int     done;
    int     pick;
    sb       = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    tx_idle  = 1'b1;
    rx_idle  = 1'b1;
    hold_req = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Full key schedule first: an encrypt must never read an unwritten key.
    // Key 0 and the last key take the word extremes.
    send_item(key_item(0, '0));
    for (int i = 1; i < NUM_ROUNDS - 1; i++) send_item(key_item(i, rand_word()));
    send_item(key_item(NUM_ROUNDS - 1, '1));

    // Plaintext extremes and patterns.
    send_item(enc_item('0, '0));
    send_item(enc_item('1, '1));
    send_item(enc_item('0, '1));
    send_item(enc_item('1, '0));
    send_item(enc_item({16{4'h5}}, {16{4'hA}}));

    // Out-of-range key indexes must be dropped; the next encrypt shows the
    // schedule is untouched. Index 63 also sets the top index bit.
    send_item(key_item(NUM_ROUNDS, '1));
    send_item(key_item(NUM_ROUNDS + 1, {16{4'hA}}));
    send_item(key_item(63, '1));
    send_item(enc_item({16{4'hA}}, {16{4'h5}}));

    // Rekey in the middle of traffic, then encrypt back to back with a load.
    send_item(key_item(5, '1));
    send_item(enc_item(rand_word(), rand_word()));
    send_item(key_item(0, {16{4'h5}}));
    send_item(enc_item(rand_word(), rand_word()));
    wait_drained();

    // Random traffic: mostly encrypts, some key reloads, a few dropped loads.
    done = 0;
    while (done < RANDOM_ITEMS) begin
      tx_idle = (done >= QUIET_PHASE);
      rx_idle = (done >= QUIET_PHASE);

      if (done == HOLD_AT) begin
        // Receiver holds off while encrypts keep coming, so the output
        // register and the finished round state fill and in_stall rises.
        hold_req = 1'b1;
        tx_idle  = 1'b0;
        for (int i = 0; i < 6; i++) send_item(enc_item(rand_word(), rand_word()));
        done += 6;
        tx_idle = 1'b1;
      end
      if (done == PAUSE_AT) wait_drained();

      pick = $urandom_range(99);
      if (pick < 70) begin
        send_item(enc_item(rand_word(), rand_word()));
        done++;
      end else if (pick < 92) begin
        send_item(key_item($urandom_range(NUM_ROUNDS - 1), rand_word()));
        done++;
      end else begin
        // dropped load, not counted
        send_item(key_item($urandom_range(63, NUM_ROUNDS), rand_word()));
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (NUM_ROUNDS + 8) @(posedge clk);

    $display("Covered %0d key loads, %0d dropped out-of-range loads, %0d encrypts;",
             sb.n_key_loads, sb.n_dropped, sb.n_encrypts);
    $display("%0d ciphertexts checked, with idle, back-to-back and back-pressure phases.",
             sb.n_checked);
    if (sb.pending() != 0) begin
      $error("%0d expected ciphertexts never arrived", sb.pending());
    end
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[speck128_block_encrypt_top.f]
rtl/spk128_pkg.sv
rtl/spk128_key_mem.sv
rtl/speck128_block_encrypt_top.sv
tb/tb.sv
